// ----- design/gspe_pkg.sv -----
// Shared types, constants and frame tables for the game-pad serial poll engine.
// Used by gspe_key_status and gamepad_serial_poll_engine_top; depends on nothing.
package gspe_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int LONG_LEN = (FRAME_BYTES < 5) ? 5 : ((FRAME_BYTES > 9) ? 9 : FRAME_BYTES);
	localparam int SHORT_LEN = (LONG_LEN < 5) ? LONG_LEN : 5;
	localparam int CHECK_LEN = 2;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [7:0] BYTE_START      = 8'h01;
	localparam logic [7:0] BYTE_POLL       = 8'h42;
	localparam logic [7:0] BYTE_CFG        = 8'h43;
	localparam logic [7:0] BYTE_ANALOG     = 8'h44;
	localparam logic [7:0] BYTE_MOTOR_MAP  = 8'h4D;
	localparam logic [7:0] BYTE_EXIT_PAD   = 8'h5A;
	localparam logic [7:0] BYTE_LOCK       = 8'h03;
	localparam logic [7:0] BYTE_ONE        = 8'h01;
	localparam logic [7:0] ID_ANALOG       = 8'h73;

	typedef enum logic [2:0] {
		FK_POLL       = 3'd0,
		FK_SHORT_POLL = 3'd1,
		FK_MOTOR      = 3'd2,
		FK_CFG_ENTER  = 3'd3,
		FK_ANALOG     = 3'd4,
		FK_MOTOR_MODE = 3'd5,
		FK_CFG_EXIT   = 3'd6,
		FK_CHECK      = 3'd7
	} frame_kind_t;

	typedef struct packed {
		logic [15:0] buttons_down;
		logic [4:0]  first_pressed;
		logic [15:0] new_presses;
	} key_status_t;

	function automatic logic [4:0] frame_len(input frame_kind_t kind);
		logic [4:0] len;
		case (kind)
			FK_SHORT_POLL, FK_MOTOR_MODE: len = 5'(SHORT_LEN);
			FK_CHECK: len = 5'(CHECK_LEN);
			default: len = 5'(LONG_LEN);
		endcase
		return len;
	endfunction

	function automatic logic [7:0] tx_byte(input frame_kind_t kind, input logic [3:0] idx,
		input logic [7:0] small_byte, input logic [7:0] large_byte);
		logic [7:0] b;
		b = 8'h00;
		if (idx == 4'd0) begin
			b = BYTE_START;
		end else if (idx == 4'd1) begin
			case (kind)
				FK_CFG_ENTER, FK_CFG_EXIT: b = BYTE_CFG;
				FK_ANALOG: b = BYTE_ANALOG;
				FK_MOTOR_MODE: b = BYTE_MOTOR_MAP;
				default: b = BYTE_POLL;
			endcase
		end else begin
			case (kind)
				FK_MOTOR: begin
					if (idx == 4'd3) b = small_byte;
					else if (idx == 4'd4) b = large_byte;
				end
				FK_CFG_ENTER: begin
					if (idx == 4'd3) b = BYTE_ONE;
				end
				FK_ANALOG: begin
					if (idx == 4'd3) b = BYTE_ONE;
					else if (idx == 4'd4) b = BYTE_LOCK;
				end
				FK_MOTOR_MODE: begin
					if (idx == 4'd4) b = BYTE_ONE;
				end
				FK_CFG_EXIT: begin
					if (idx >= 4'd4) b = BYTE_EXIT_PAD;
				end
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

// ----- design/gspe_key_status.sv -----
// Button status decode: pressed mask, lowest pressed button and new presses.
// Depends on gspe_pkg for key_status_t.
module gspe_key_status import gspe_pkg::*; (
	input  logic [15:0] raw_keys,
	input  logic [15:0] previous_keys,
	output key_status_t status
);

	logic [15:0] down;
	logic [4:0]  first;

	assign down = ~raw_keys;

	always_comb begin
		first = 5'd0;
		for (int i = 15; i >= 0; i--) begin
			if (down[i]) first = 5'(i + 1);
		end
	end

	assign status.buttons_down  = down;
	assign status.first_pressed = first;
	assign status.new_presses   = previous_keys & down;

endmodule

// ----- design/gamepad_serial_poll_engine_top.sv -----
// Top level of the game-pad serial poll engine: input register, frame state and result register.
// Depends on gspe_pkg and gspe_key_status.
//
// Each input word is either a start, which opens one of eight fixed frames if none is open and
// asserts chip select, or a bit tick, which drives one bit of the current command
// byte (LSB first) and samples one bit from the pad. Every accepted word yields
// exactly one result word with the link bits and the status after that word.
// Input words enter through item_valid and item_stall and land in an input
// register; results leave through result_valid and result_stall from a result
// register. A result is registered from the word held in the input register, and a
// new word is accepted every cycle while the receiver takes results.
// When result_stall holds a waiting result, the input register fills and then
// item_stall rises, so no word is lost or repeated.
// Reset clears the frame state, sets both key images to all ones (nothing
// pressed) and empties both registers.
module gamepad_serial_poll_engine_top import gspe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        cmd,
	input  logic [2:0]  frame_kind,
	input  logic [7:0]  motor_small,
	input  logic [7:0]  motor_large,
	input  logic        data_in_bit,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        select_active,
	output logic        data_out_bit,
	output logic        frame_done,
	output logic [7:0]  pad_id,
	output logic        analog_mode,
	output logic [15:0] buttons_down,
	output logic [4:0]  first_pressed,
	output logic [15:0] new_presses,
	output logic [7:0]  right_x,
	output logic [7:0]  right_y,
	output logic [7:0]  left_x,
	output logic [7:0]  left_y
);

	logic        valid_s1;
	logic        cmd_s1;
	frame_kind_t kind_s1;
	logic [7:0]  small_s1;
	logic [7:0]  large_s1;
	logic        din_s1;

	logic        busy_q;
	frame_kind_t kind_q;
	logic [2:0]  bit_q;
	logic [3:0]  byte_q;
	logic [7:0]  shift_q;
	logic [7:0]  motor_q [2];
	logic [7:0]  id_q;
	logic [15:0] raw_q;
	logic [15:0] prev_q;
	logic [7:0]  stick_q [4];

	logic        busy_d;
	frame_kind_t kind_d;
	logic [2:0]  bit_d;
	logic [3:0]  byte_d;
	logic [7:0]  shift_d;
	logic [7:0]  motor_d [2];
	logic [7:0]  id_d;
	logic [15:0] raw_d;
	logic [15:0] prev_d;
	logic [7:0]  stick_d [4];
	logic        sel_d;
	logic        dout_d;
	logic        done_d;
	logic [7:0]  tx_d;
	logic [7:0]  rx_d;
	logic [4:0]  next_byte;

	logic        advance;
	key_status_t keys_d;

	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1   <= cmd;
			kind_s1  <= frame_kind_t'(frame_kind);
			small_s1 <= motor_small;
			large_s1 <= motor_large;
			din_s1   <= data_in_bit;
		end
	end

	always_comb begin
		busy_d     = busy_q;
		kind_d     = kind_q;
		bit_d      = bit_q;
		byte_d     = byte_q;
		shift_d    = shift_q;
		motor_d    = motor_q;
		id_d       = id_q;
		raw_d      = raw_q;
		prev_d     = prev_q;
		stick_d    = stick_q;
		sel_d      = 1'b0;
		dout_d     = 1'b0;
		done_d     = 1'b0;
		tx_d       = tx_byte(kind_q, byte_q, motor_q[0], motor_q[1]);
		rx_d       = shift_q | (8'(din_s1) << bit_q);
		next_byte  = 5'(byte_q) + 5'd1;
		if (cmd_s1 == CMD_START) begin
			if (!busy_q) begin
				busy_d     = 1'b1;
				kind_d     = kind_s1;
				bit_d      = 3'd0;
				byte_d     = 4'd0;
				shift_d    = 8'h00;
				motor_d[0] = small_s1;
				motor_d[1] = large_s1;
				if (kind_s1 == FK_POLL) begin
					for (int i = 0; i < 4; i++) stick_d[i] = 8'h00;
				end
			end
			sel_d = 1'b1;
		end else if (busy_q) begin
			sel_d   = 1'b1;
			dout_d  = tx_d[bit_q];
			shift_d = rx_d;
			if (bit_q == 3'd7) begin
				if (byte_q == 4'd1) begin
					id_d = rx_d;
				end else if (kind_q == FK_POLL) begin
					case (byte_q)
						4'd3: begin
							prev_d = raw_q;
							raw_d  = {raw_q[15:8], rx_d};
						end
						4'd4: raw_d = {rx_d, raw_q[7:0]};
						4'd5: stick_d[0] = rx_d;
						4'd6: stick_d[1] = rx_d;
						4'd7: stick_d[2] = rx_d;
						4'd8: stick_d[3] = rx_d;
						default: ;
					endcase
				end
				shift_d = 8'h00;
				bit_d   = 3'd0;
				byte_d  = next_byte[3:0];
				if (next_byte >= frame_len(kind_q)) begin
					done_d = 1'b1;
					busy_d = 1'b0;
					byte_d = 4'd0;
				end
			end else begin
				bit_d = bit_q + 3'd1;
			end
		end
	end

	gspe_key_status u_key_status (
		.raw_keys      (raw_d),
		.previous_keys (prev_d),
		.status        (keys_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			kind_q  <= FK_POLL;
			bit_q   <= 3'd0;
			byte_q  <= 4'd0;
			shift_q <= 8'h00;
			motor_q <= '{default: 8'h00};
			id_q    <= 8'h00;
			raw_q   <= 16'hFFFF;
			prev_q  <= 16'hFFFF;
			stick_q <= '{default: 8'h00};
		end else if (advance) begin
			busy_q  <= busy_d;
			kind_q  <= kind_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			shift_q <= shift_d;
			motor_q <= motor_d;
			id_q    <= id_d;
			raw_q   <= raw_d;
			prev_q  <= prev_d;
			stick_q <= stick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			select_active <= sel_d;
			data_out_bit  <= dout_d;
			frame_done    <= done_d;
			pad_id        <= id_d;
			analog_mode   <= (id_d == ID_ANALOG);
			buttons_down  <= keys_d.buttons_down;
			first_pressed <= keys_d.first_pressed;
			new_presses   <= keys_d.new_presses;
			right_x       <= stick_d[0];
			right_y       <= stick_d[1];
			left_x        <= stick_d[2];
			left_y        <= stick_d[3];
		end
	end

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		advance && done_d |=> !busy_q && byte_q == 4'd0)
		else $error("Frame end did not return the engine to idle.");

	a_idle_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> bit_q == 3'd0 && byte_q == 4'd0 && shift_q == 8'h00)
		else $error("Bit or byte position left over while idle.");

	a_done_has_select: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |-> select_active)
		else $error("Frame end reported without chip select.");

	a_first_matches_down: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (first_pressed == 5'd0) == (buttons_down == 16'h0000))
		else $error("Lowest pressed button disagrees with the button mask.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(buttons_down)
			&& $stable(frame_done))
		else $error("Stalled result word changed.");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for gamepad_serial_poll_engine_top: queued pad words, a clocked
// driver and monitor, and an in-bench prediction of the link bits and key/stick status.
// Depends on gspe_pkg and the design files of the poll engine.
module testbench import gspe_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 100000;
	localparam int WORD_TARGET = 1700;

	typedef struct {
		logic       cmd;
		logic [2:0] kind;
		logic [7:0] rumble_lo;
		logic [7:0] rumble_hi;
		logic       din;
		bit         drain;
	} pad_word_t;

	typedef struct {
		logic        sel;
		logic        dout;
		logic        done;
		logic [7:0]  id;
		logic        analog;
		logic [15:0] down;
		logic [4:0]  first;
		logic [15:0] fresh;
		logic [7:0]  rx;
		logic [7:0]  ry;
		logic [7:0]  lx;
		logic [7:0]  ly;
	} pad_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        cmd = CMD_TICK;
	logic [2:0]  frame_kind = 3'd0;
	logic [7:0]  motor_small = 8'h00;
	logic [7:0]  motor_large = 8'h00;
	logic        data_in_bit = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        select_active;
	logic        data_out_bit;
	logic        frame_done;
	logic [7:0]  pad_id;
	logic        analog_mode;
	logic [15:0] buttons_down;
	logic [4:0]  first_pressed;
	logic [15:0] new_presses;
	logic [7:0]  right_x;
	logic [7:0]  right_y;
	logic [7:0]  left_x;
	logic [7:0]  left_y;

	pad_word_t   pending[$];
	pad_status_t status_due[$];
	pad_word_t   live_word;
	int          errors = 0;
	int          cycles = 0;
	logic        calm;

	logic        link_busy = 1'b0;
	frame_kind_t link_kind = FK_POLL;
	logic [2:0]  bit_pos = 3'd0;
	logic [3:0]  byte_pos = 4'd0;
	logic [7:0]  rx_shift = 8'h00;
	logic [7:0]  rumble[2] = '{8'h00, 8'h00};
	logic [7:0]  id_byte = 8'h00;
	logic [15:0] keys_raw = 16'hFFFF;
	logic [15:0] keys_prev = 16'hFFFF;
	logic [7:0]  sticks[4] = '{8'h00, 8'h00, 8'h00, 8'h00};

	gamepad_serial_poll_engine_top uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(cmd), .frame_kind(frame_kind), .motor_small(motor_small),
		.motor_large(motor_large), .data_in_bit(data_in_bit),
		.result_valid(result_valid), .result_stall(result_stall),
		.select_active(select_active), .data_out_bit(data_out_bit), .frame_done(frame_done),
		.pad_id(pad_id), .analog_mode(analog_mode), .buttons_down(buttons_down),
		.first_pressed(first_pressed), .new_presses(new_presses),
		.right_x(right_x), .right_y(right_y), .left_x(left_x), .left_y(left_y)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	assign calm = (cycles >= 600) && (cycles < 1400);

	function automatic int frame_bytes(input frame_kind_t k);
		int longest;
		longest = (FRAME_BYTES < 5) ? 5 : ((FRAME_BYTES > 9) ? 9 : FRAME_BYTES);
		case (k)
			FK_SHORT_POLL, FK_MOTOR_MODE: return (longest < 5) ? longest : 5;
			FK_CHECK: return 2;
			default: return longest;
		endcase
	endfunction

	function automatic logic [7:0] sent_byte(input frame_kind_t k, input logic [3:0] idx);
		if (idx == 4'd0)
			return BYTE_START;
		if (idx == 4'd1) begin
			case (k)
				FK_CFG_ENTER, FK_CFG_EXIT: return BYTE_CFG;
				FK_ANALOG: return BYTE_ANALOG;
				FK_MOTOR_MODE: return BYTE_MOTOR_MAP;
				default: return BYTE_POLL;
			endcase
		end
		case (k)
			FK_MOTOR: return (idx == 4'd3) ? rumble[0] : ((idx == 4'd4) ? rumble[1] : 8'h00);
			FK_CFG_ENTER: return (idx == 4'd3) ? BYTE_ONE : 8'h00;
			FK_ANALOG: return (idx == 4'd3) ? BYTE_ONE : ((idx == 4'd4) ? BYTE_LOCK : 8'h00);
			FK_MOTOR_MODE: return (idx == 4'd4) ? BYTE_ONE : 8'h00;
			FK_CFG_EXIT: return (idx >= 4'd4) ? BYTE_EXIT_PAD : 8'h00;
			default: return 8'h00;
		endcase
	endfunction

	task automatic link_step(input pad_word_t w);
		pad_status_t s;
		logic [7:0]  b;
		logic [7:0]  r;
		s = '{default: '0};
		if (w.cmd == CMD_START) begin
			if (!link_busy) begin
				link_busy = 1'b1;
				link_kind = frame_kind_t'(w.kind);
				bit_pos = 3'd0;
				byte_pos = 4'd0;
				rx_shift = 8'h00;
				rumble[0] = w.rumble_lo;
				rumble[1] = w.rumble_hi;
				if (link_kind == FK_POLL)
					sticks = '{8'h00, 8'h00, 8'h00, 8'h00};
			end
			s.sel = link_busy;
		end else if (link_busy) begin
			b = sent_byte(link_kind, byte_pos);
			s.sel = 1'b1;
			s.dout = b[bit_pos];
			rx_shift[bit_pos] = rx_shift[bit_pos] | w.din;
			if (bit_pos == 3'd7) begin
				r = rx_shift;
				if (byte_pos == 4'd1) begin
					id_byte = r;
				end else if (link_kind == FK_POLL) begin
					if (byte_pos == 4'd3) begin
						keys_prev = keys_raw;
						keys_raw[7:0] = r;
					end else if (byte_pos == 4'd4) begin
						keys_raw[15:8] = r;
					end else if (byte_pos >= 4'd5 && byte_pos <= 4'd8) begin
						sticks[byte_pos - 4'd5] = r;
					end
				end
				rx_shift = 8'h00;
				bit_pos = 3'd0;
				byte_pos = byte_pos + 4'd1;
				if (int'(byte_pos) >= frame_bytes(link_kind)) begin
					s.done = 1'b1;
					link_busy = 1'b0;
					byte_pos = 4'd0;
				end
			end else begin
				bit_pos = bit_pos + 3'd1;
			end
		end
		s.id = id_byte;
		s.analog = (id_byte == ID_ANALOG);
		s.down = ~keys_raw;
		for (int i = 15; i >= 0; i--)
			if (s.down[i])
				s.first = 5'(i + 1);
		s.fresh = keys_prev & s.down;
		s.rx = sticks[0];
		s.ry = sticks[1];
		s.lx = sticks[2];
		s.ly = sticks[3];
		status_due.push_back(s);
	endtask

	task automatic add_word(input logic c, input logic [2:0] k, input logic [7:0] lo, hi,
		input logic d, input bit drain);
		pad_word_t w;
		w = '{cmd: c, kind: k, rumble_lo: lo, rumble_hi: hi, din: d, drain: drain};
		pending.push_back(w);
	endtask

	task automatic queue_frame(input frame_kind_t k, input logic [7:0] lo, hi,
		input logic [71:0] pad_bytes, input bit noisy, input bit drain);
		int n;
		int stray;
		n = frame_bytes(k) * 8;
		stray = noisy ? $urandom_range(1, n - 1) : -1;
		add_word(CMD_START, k, lo, hi, 1'($urandom_range(0, 1)), drain);
		for (int t = 0; t < n; t++) begin
			if (t == stray)
				add_word(CMD_START, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
					1'($urandom_range(0, 1)), 1'b0);
			add_word(CMD_TICK, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
				pad_bytes[t], 1'b0);
		end
	endtask

	function automatic logic [71:0] pad_reply(input logic [7:0] id, input logic [15:0] keys,
		input logic [31:0] stick_word);
		return {stick_word, keys, 8'($urandom), id, 8'($urandom)};
	endfunction

	task automatic complain(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
		errors++;
	endtask

	task automatic check_result();
		pad_status_t want;
		if (status_due.size() == 0) begin
			complain("result with nothing pending", 0, 0);
		end else begin
			want = status_due.pop_front();
			if (select_active !== want.sel) complain("select_active", select_active, want.sel);
			if (data_out_bit !== want.dout) complain("data_out_bit", data_out_bit, want.dout);
			if (frame_done !== want.done) complain("frame_done", frame_done, want.done);
			if (pad_id !== want.id) complain("pad_id", pad_id, want.id);
			if (analog_mode !== want.analog) complain("analog_mode", analog_mode, want.analog);
			if (buttons_down !== want.down) complain("buttons_down", buttons_down, want.down);
			if (first_pressed !== want.first)
				complain("first_pressed", first_pressed, want.first);
			if (new_presses !== want.fresh) complain("new_presses", new_presses, want.fresh);
			if (right_x !== want.rx) complain("right_x", right_x, want.rx);
			if (right_y !== want.ry) complain("right_y", right_y, want.ry);
			if (left_x !== want.lx) complain("left_x", left_x, want.lx);
			if (left_y !== want.ly) complain("left_y", left_y, want.ly);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			cmd <= CMD_TICK;
			frame_kind <= 3'd0;
			motor_small <= 8'h00;
			motor_large <= 8'h00;
			data_in_bit <= 1'b0;
		end else begin : drive
			bit gap;
			gap = !calm && ($urandom_range(0, 99) < 19);
			if (item_valid && !item_stall)
				link_step(live_word);
			if (!item_valid || !item_stall) begin
				if (pending.size() != 0 && !gap
					&& !(pending[0].drain && status_due.size() != 0)) begin
					live_word = pending.pop_front();
					item_valid <= 1'b1;
					cmd <= live_word.cmd;
					frame_kind <= live_word.kind;
					motor_small <= live_word.rumble_lo;
					motor_large <= live_word.rumble_hi;
					data_in_bit <= live_word.din;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				check_result();
			result_stall <= !calm && ($urandom_range(0, 99) < 19);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		frame_kind_t k;
		logic [7:0]  id;
		logic [15:0] keys;

		// Directed frames: idle tick, interrupted check, key and stick extremes, every kind.
		add_word(CMD_TICK, 3'd5, 8'hFF, 8'hFF, 1'b1, 1'b0);
		queue_frame(FK_CHECK, 8'hFF, 8'h00, pad_reply(ID_ANALOG, 16'h0, 32'h0), 1'b1, 1'b1);
		queue_frame(FK_POLL, 8'hFF, 8'h00, pad_reply(ID_ANALOG, 16'h0000, 32'h00FF00FF),
			1'b0, 1'b0);
		queue_frame(FK_POLL, 8'h00, 8'hFF, pad_reply(8'h41, 16'hFFFF, 32'hFFFFFFFF), 1'b0, 1'b0);
		queue_frame(FK_POLL, 8'h55, 8'hAA, pad_reply(8'hFF, 16'h7FFF, 32'h12345678), 1'b0, 1'b0);
		queue_frame(FK_SHORT_POLL, 8'h00, 8'h00, pad_reply(8'h00, 16'h0000, 32'h0), 1'b0, 1'b0);
		queue_frame(FK_MOTOR, 8'hFF, 8'hFF, pad_reply(ID_ANALOG, 16'h1234, 32'h0), 1'b0, 1'b0);
		queue_frame(FK_MOTOR, 8'h00, 8'h00, pad_reply(8'h41, 16'h0, 32'h0), 1'b0, 1'b0);
		queue_frame(FK_CFG_ENTER, 8'h0F, 8'hF0, pad_reply(8'hF3, 16'h0, 32'h0), 1'b0, 1'b0);
		queue_frame(FK_ANALOG, 8'hA5, 8'h5A, pad_reply(8'h73, 16'h0, 32'h0), 1'b0, 1'b0);
		queue_frame(FK_MOTOR_MODE, 8'h3C, 8'hC3, pad_reply(8'hF3, 16'h0, 32'h0), 1'b0, 1'b0);
		queue_frame(FK_CFG_EXIT, 8'h81, 8'h18, pad_reply(8'h41, 16'h0, 32'h0), 1'b0, 1'b0);
		queue_frame(FK_POLL, 8'h00, 8'h00, pad_reply(8'h41, 16'hFFFE, 32'h0), 1'b0, 1'b1);

		while (pending.size() < WORD_TARGET) begin
			if ($urandom_range(0, 99) < 6) begin
				add_word(CMD_TICK, 3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
					1'($urandom_range(0, 1)), 1'b0);
			end else begin
				k = ($urandom_range(0, 9) < 4) ? FK_POLL : frame_kind_t'($urandom_range(0, 7));
				case ($urandom_range(0, 2))
					0: id = ID_ANALOG;
					1: id = 8'h41;
					default: id = 8'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: keys = 16'hFFFF;
					1: keys = ~(16'h0001 << $urandom_range(0, 15));
					default: keys = 16'($urandom);
				endcase
				queue_frame(k, 8'($urandom), 8'($urandom), pad_reply(id, keys, $urandom),
					$urandom_range(0, 99) < 15, $urandom_range(0, 99) < 10);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || item_valid)
			@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
